>>> src/ufn_pkg.sv
// Shared types and fixed widths for the unit face normal block.
`default_nettype none
package ufn_pkg;

  localparam int COORD_W = 16;  // vertex coordinate width
  localparam int NORM_W  = 16;  // normal component width

  localparam int EDGE_W  = COORD_W + 1;        // edge vector component
  localparam int PROD_W  = 2 * EDGE_W;         // signed edge product
  localparam int MAG_W   = 2 * EDGE_W;         // cross component magnitude
  localparam int SQ_W    = 2 * MAG_W;          // squared magnitude
  localparam int ROOT_W  = MAG_W + 1;          // integer sqrt result
  localparam int LEN_W   = 2 * ROOT_W;         // squared length

  typedef struct packed {
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
  } in_data_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
  } out_data_t;

  // cross product in sign/magnitude form
  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } cross_t;

endpackage
`default_nettype wire

>>> src/ufn_front.sv
// Edge vectors, cross product and squared length, five register stages.
`default_nettype none
module ufn_front
  import ufn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire in_data_t         in_data,
  output logic                  valid_o,
  output logic [LEN_W-1:0]      len_o,
  output cross_t                cross_o,
  output logic                  deg_o
);

  logic [4:0] v_r;

  logic signed [EDGE_W-1:0] ax_nxt, ay_nxt, az_nxt, bx_nxt, by_nxt, bz_nxt;
  logic signed [EDGE_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [5:0][PROD_W-1:0] pr_nxt, pr_r;
  logic signed [PROD_W:0] c0, c1, c2;
  cross_t cr_nxt, cr_r, cr2_r, cr3_r;
  logic [2:0][SQ_W-1:0] sq_r;
  logic deg_nxt, deg_r, deg2_r;
  logic [LEN_W-1:0] len_r;

  assign ax_nxt = EDGE_W'(in_data.p2_x) - EDGE_W'(in_data.p1_x);
  assign ay_nxt = EDGE_W'(in_data.p2_y) - EDGE_W'(in_data.p1_y);
  assign az_nxt = EDGE_W'(in_data.p2_z) - EDGE_W'(in_data.p1_z);
  assign bx_nxt = EDGE_W'(in_data.p3_x) - EDGE_W'(in_data.p1_x);
  assign by_nxt = EDGE_W'(in_data.p3_y) - EDGE_W'(in_data.p1_y);
  assign bz_nxt = EDGE_W'(in_data.p3_z) - EDGE_W'(in_data.p1_z);

  assign pr_nxt[0] = PROD_W'(ay_r) * PROD_W'(bz_r);
  assign pr_nxt[1] = PROD_W'(az_r) * PROD_W'(by_r);
  assign pr_nxt[2] = PROD_W'(az_r) * PROD_W'(bx_r);
  assign pr_nxt[3] = PROD_W'(ax_r) * PROD_W'(bz_r);
  assign pr_nxt[4] = PROD_W'(ax_r) * PROD_W'(by_r);
  assign pr_nxt[5] = PROD_W'(ay_r) * PROD_W'(bx_r);

  assign c0 = (PROD_W+1)'($signed(pr_r[0])) - (PROD_W+1)'($signed(pr_r[1]));
  assign c1 = (PROD_W+1)'($signed(pr_r[2])) - (PROD_W+1)'($signed(pr_r[3]));
  assign c2 = (PROD_W+1)'($signed(pr_r[4])) - (PROD_W+1)'($signed(pr_r[5]));

  always_comb begin
    cr_nxt.neg[0] = c0[PROD_W];
    cr_nxt.neg[1] = c1[PROD_W];
    cr_nxt.neg[2] = c2[PROD_W];
    cr_nxt.mag[0] = c0[PROD_W] ? MAG_W'(-c0) : MAG_W'(c0);
    cr_nxt.mag[1] = c1[PROD_W] ? MAG_W'(-c1) : MAG_W'(c1);
    cr_nxt.mag[2] = c2[PROD_W] ? MAG_W'(-c2) : MAG_W'(c2);
  end

  assign deg_nxt = (cr_r.mag[0] == '0) && (cr_r.mag[1] == '0) && (cr_r.mag[2] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt; ay_r <= ay_nxt; az_r <= az_nxt;
      bx_r <= bx_nxt; by_r <= by_nxt; bz_r <= bz_nxt;
      pr_r <= pr_nxt;
      cr_r <= cr_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(cr_r.mag[i]) * SQ_W'(cr_r.mag[i]);
      end
      cr2_r  <= cr_r;
      deg_r  <= deg_nxt;
      len_r  <= LEN_W'(sq_r[0]) + LEN_W'(sq_r[1]) + LEN_W'(sq_r[2]);
      cr3_r  <= cr2_r;
      deg2_r <= deg_r;
    end
  end

  assign valid_o = v_r[4];
  assign len_o   = len_r;
  assign cross_o = cr3_r;
  assign deg_o   = deg2_r;

endmodule
`default_nettype wire

>>> src/ufn_sqrt_cell.sv
// One root bit of the integer square root chain.
`default_nettype none
module ufn_sqrt_cell
  import ufn_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire logic [LEN_W-1:0]  x_i,
  input  wire logic [ROOT_W+1:0] rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [LEN_W-1:0]       x_o,
  output logic [ROOT_W+1:0]      rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [ROOT_W+1:0] r, trial;
  logic              ge;
  logic              valid_r;
  logic [LEN_W-1:0]  x_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SIDE_W-1:0] side_r;

  // remainder never exceeds twice the partial root, so its top bits are zero here
  assign r     = {rem_i[ROOT_W-1:0], x_i[LEN_W-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge    = (r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[LEN_W-3:0], 2'b00};
      rem_r  <= ge ? (r - trial) : r;
      root_r <= {root_i[ROOT_W-2:0], ge};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

>>> src/ufn_div_cell.sv
// One quotient bit for all three normal components.
`default_nettype none
module ufn_div_cell
  import ufn_pkg::*;
#(
  parameter int Q_W    = 15,
  parameter int SIDE_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  valid_i,
  input  wire logic [ROOT_W-1:0]     s_i,
  input  wire logic [2:0][ROOT_W:0]  rem_i,
  input  wire logic [2:0][Q_W-1:0]   q_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  output logic                       valid_o,
  output logic [ROOT_W-1:0]          s_o,
  output logic [2:0][ROOT_W:0]       rem_o,
  output logic [2:0][Q_W-1:0]        q_o,
  output logic [SIDE_W-1:0]          side_o
);

  logic [2:0][ROOT_W:0]  rem_nxt;
  logic [2:0][Q_W-1:0]   q_nxt;
  logic                  valid_r;
  logic [ROOT_W-1:0]     s_r;
  logic [2:0][ROOT_W:0]  rem_r;
  logic [2:0][Q_W-1:0]   q_r;
  logic [SIDE_W-1:0]     side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic            ge;
      logic [ROOT_W:0] d;
      ge = (rem_i[i] >= {1'b0, s_i});
      d  = ge ? (rem_i[i] - {1'b0, s_i}) : rem_i[i];
      // d < s, so the doubled remainder fits
      rem_nxt[i] = {d[ROOT_W-1:0], 1'b0};
      q_nxt[i]   = {q_i[i][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign s_o     = s_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

>>> src/unit_face_normal.sv
// Pipeline order: front end, square root chain, division chain, output register.
// Throughput: one transaction per cycle; the whole pipeline advances together,
// held only while the output register is full and out_ready is low.
// Square root is one cell per root bit, division one cell per quotient bit.
// Reset (rst_n, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module unit_face_normal
  import ufn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_data_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_data_t      out_data
);

  localparam int Q_W     = NORMAL_FRAC_BITS + 1;
  localparam int QX_W    = (Q_W > NORM_W) ? Q_W : NORM_W;
  localparam int SSIDE_W = 1 + $bits(cross_t);
  localparam int DSIDE_W = 4;

  logic en;
  logic out_valid_r;
  out_data_t out_data_r, out_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic             f_valid;
  logic [LEN_W-1:0] f_len;
  cross_t           f_cross;
  logic             f_deg;

  ufn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .valid_o  (f_valid),
    .len_o    (f_len),
    .cross_o  (f_cross),
    .deg_o    (f_deg)
  );

  // square root chain
  logic [ROOT_W:0]                 sv;
  logic [ROOT_W:0][LEN_W-1:0]      sx;
  logic [ROOT_W:0][ROOT_W+1:0]     srem;
  logic [ROOT_W:0][ROOT_W-1:0]     sroot;
  logic [ROOT_W:0][SSIDE_W-1:0]    sside;

  assign sv[0]    = f_valid;
  assign sx[0]    = f_len;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = {f_deg, f_cross};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    ufn_sqrt_cell #(.SIDE_W(SSIDE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sv[g]),
      .x_i     (sx[g]),
      .rem_i   (srem[g]),
      .root_i  (sroot[g]),
      .side_i  (sside[g]),
      .valid_o (sv[g+1]),
      .x_o     (sx[g+1]),
      .rem_o   (srem[g+1]),
      .root_o  (sroot[g+1]),
      .side_o  (sside[g+1])
    );
  end

  cross_t s_cross;
  logic   s_deg;
  assign {s_deg, s_cross} = sside[ROOT_W];

  // division chain
  logic [Q_W:0]                    dv;
  logic [Q_W:0][ROOT_W-1:0]        ds;
  logic [Q_W:0][2:0][ROOT_W:0]     drem;
  logic [Q_W:0][2:0][Q_W-1:0]      dq;
  logic [Q_W:0][DSIDE_W-1:0]       dside;

  assign dv[0]   = sv[ROOT_W];
  assign ds[0]   = sroot[ROOT_W];
  assign dq[0]   = '0;
  assign dside[0] = {s_deg, s_cross.neg};
  for (genvar c = 0; c < 3; c++) begin : g_rem0
    assign drem[0][c] = (ROOT_W+1)'(s_cross.mag[c]);
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    ufn_div_cell #(.Q_W(Q_W), .SIDE_W(DSIDE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv[g]),
      .s_i     (ds[g]),
      .rem_i   (drem[g]),
      .q_i     (dq[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .s_o     (ds[g+1]),
      .rem_o   (drem[g+1]),
      .q_o     (dq[g+1]),
      .side_o  (dside[g+1])
    );
  end

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << NORMAL_FRAC_BITS;

  logic [2:0][NORM_W-1:0] comp;
  logic                   d_deg;
  logic [2:0]             d_neg;
  assign {d_deg, d_neg} = dside[Q_W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [Q_W-1:0]  qc;
      logic [QX_W-1:0] qx;
      qc = (dq[Q_W][i] > ONE) ? ONE : dq[Q_W][i];
      qx = QX_W'(qc);
      if (d_deg) begin
        comp[i] = '0;
      end else if (d_neg[i]) begin
        comp[i] = -qx[NORM_W-1:0];
      end else begin
        comp[i] = qx[NORM_W-1:0];
      end
    end
    out_nxt.norm_x     = comp[0];
    out_nxt.norm_y     = comp[1];
    out_nxt.norm_z     = comp[2];
    out_nxt.degenerate = d_deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> src/ufn_checker.sv
// Port-level checks for unit_face_normal and the bind that attaches them.
`default_nettype none
module ufn_checker
  import ufn_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_data_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_data_t out_data
);

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0)
    else $error("degenerate result with nonzero normal");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind unit_face_normal ufn_checker u_ufn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/tb.sv
// Testbench for unit_face_normal: directed and randomized triangles checked against a local predictor.
`default_nettype none
module tb;
  import ufn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int LATENCY = 56;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM = 1330;

  class normal_scoreboard;
    out_data_t expected_q[$];
    int mismatches = 0;

    function automatic logic [127:0] isqrt(logic [127:0] x);
      logic [127:0] res, bit_v, t;
      res = '0;
      bit_v = 128'd1 << 126;
      while (bit_v != 0) begin
        t = res + bit_v;
        if (x >= t) begin
          x = x - t;
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return res;
    endfunction

    function automatic out_data_t face_normal(in_data_t d);
      longint ax, ay, az, bx, by, bz;
      longint n[3];
      logic [127:0] m[3], len, root, q;
      out_data_t r;
      ax = longint'(d.p2_x) - longint'(d.p1_x);
      ay = longint'(d.p2_y) - longint'(d.p1_y);
      az = longint'(d.p2_z) - longint'(d.p1_z);
      bx = longint'(d.p3_x) - longint'(d.p1_x);
      by = longint'(d.p3_y) - longint'(d.p1_y);
      bz = longint'(d.p3_z) - longint'(d.p1_z);
      n[0] = ay * bz - az * by;
      n[1] = az * bx - ax * bz;
      n[2] = ax * by - ay * bx;
      len = '0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
        len = len + m[i] * m[i];
      end
      r = '0;
      if (len == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      root = isqrt(len);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] << FRAC) / root;
        if (q > (128'd1 << FRAC)) q = 128'd1 << FRAC;
        if (n[i] < 0) q = -q;
        case (i)
          0: r.norm_x = q[15:0];
          1: r.norm_y = q[15:0];
          default: r.norm_z = q[15:0];
        endcase
      end
      return r;
    endfunction

    function void note_triangle(in_data_t d);
      expected_q.insert(expected_q.size(), face_normal(d));
    endfunction

    function void check_normal(out_data_t got);
      out_data_t exp_v;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_v = expected_q.pop_front();
      if (got.norm_x !== exp_v.norm_x || got.norm_y !== exp_v.norm_y ||
          got.norm_z !== exp_v.norm_z || got.degenerate !== exp_v.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d z=%0d deg=%b got x=%0d y=%0d z=%0d deg=%b",
                   exp_v.norm_x, exp_v.norm_y, exp_v.norm_z, exp_v.degenerate,
                   got.norm_x, got.norm_y, got.norm_z, got.degenerate);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_data_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_data_t out_data;

  normal_scoreboard sb = new();
  int cycles = 0;
  int accepted = 0;
  bit hold_done = 0;

  unit_face_normal #(.NORMAL_FRAC_BITS(FRAC)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_triangle(in_data);
      accepted <= accepted + 1;
    end
    if (rst_n && out_valid && out_ready) sb.check_normal(out_data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, stretches of constant readiness, one long hold-off while the sender keeps offering
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted >= 400) begin
        hold_done = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ((accepted / 150) % 2 == 1) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (pick_gap() == 0);
      end
    end
  end

  bit no_gaps = 0;

  task automatic send_triangle(in_data_t d);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(15)) - 16'd8;
      2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(1023)) - 16'd512;
    endcase
  endfunction

  function automatic in_data_t rand_triangle();
    in_data_t d;
    int mode, k;
    mode = $urandom_range(3);
    d = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode)};
    if ($urandom_range(19) == 0) begin
      // collinear: p3 on the line through p1 and p2
      d = '0;
      d.p1_x = rand_coord(3); d.p1_y = rand_coord(3); d.p1_z = rand_coord(3);
      d.p2_x = d.p1_x + rand_coord(1); d.p2_y = d.p1_y + rand_coord(1);
      d.p2_z = d.p1_z + rand_coord(1);
      k = $urandom_range(3);
      d.p3_x = d.p1_x + 16'(k) * (d.p2_x - d.p1_x);
      d.p3_y = d.p1_y + 16'(k) * (d.p2_y - d.p1_y);
      d.p3_z = d.p1_z + 16'(k) * (d.p2_z - d.p1_z);
    end
    return d;
  endfunction

  in_data_t directed[$];

  function automatic void add_directed(in_data_t d);
    directed.insert(directed.size(), d);
  endfunction

  initial begin
    in_data_t d;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_directed('0);
    add_directed({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0});
    add_directed({16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100});
    add_directed({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0, 16'h0});
    add_directed({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000});
    add_directed({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h8000});
    add_directed({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h8000});
    add_directed({16'h7fff, 16'h8000, 16'h0, 16'h8000, 16'h7fff, 16'h0,
                  16'h8000, 16'h8000, 16'h7fff});
    add_directed({16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
                  16'h1234, 16'h1234, 16'h1234});
    add_directed({16'h0, 16'h0, 16'h0, 16'h0001, 16'h0001, 16'h0001,
                  16'h0002, 16'h0002, 16'h0002});
    add_directed({16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0,
                  16'h7fff, 16'h7fff, 16'h7fff});
    add_directed({16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0});
    add_directed({16'hffff, 16'hffff, 16'hffff, 16'h0, 16'hffff, 16'hffff,
                  16'hffff, 16'h0, 16'h0});
    add_directed({16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0001, 16'h0,
                  16'h0001, 16'h7fff, 16'h0});
    foreach (directed[i]) send_triangle(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = ((i / 100) % 3 == 2);
      d = rand_triangle();
      send_triangle(d);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
